@@ rtl/core/sprq_pkg.sv @@
// Shared types and constants for the serial receive ring queue.
// Used by the control sequencer, the top level and the port checker.
`default_nettype none
package sprq_pkg;

  // Defaults and fixed field widths.
  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int BYTE_W          = 8;
  localparam int LIMIT_W         = 7;
  localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd10;
  localparam logic [BYTE_W-1:0] TERM_BYTE   = 8'd0;

  // Request kinds carried on the input tuser bit.
  localparam logic REQ_RX   = 1'b0;
  localparam logic REQ_COPY = 1'b1;

  // Register map: byte addresses.
  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-1:0] ADDR_DELIM = 3'd0;

  // One input beat, unpacked.
  typedef struct packed {
    logic               req_type;
    logic [BYTE_W-1:0]  rx_byte;
    logic [LIMIT_W-1:0] copy_limit;
  } req_t;

  // One result beat, unpacked.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              from_copy;
    logic              last;
    logic              message_ready;
    logic              queue_empty;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/core/spi_rx_ring_queue_with_delimiter_top.sv @@
// Top level of the serial receive ring queue: stream ports, register port, ring RAM.
// Depends on sprq_pkg, sprq_ram and sprq_ctrl.
// A receive beat's status beat is registered from state ST_RX_OUT and waits there while the result register is full.
// A new request is taken only in the idle state, after the last one is through; a copy reads a byte in ST_COPY_RD,
// takes the registered ring RAM read in ST_COPY_WAIT, and emits the terminator from ST_COPY_END.
// Reset (rst, synchronous): queue empty, both pointers 0, flag clear, delimiter 10.
`default_nettype none
module spi_rx_ring_queue_with_delimiter_top #(
  parameter int QUEUE_DEPTH = sprq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Input stream
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [15:0]                 s_tdata,  // rx_byte[7:0], copy_limit[14:8], 0
  input  wire logic                        s_tuser,  // req_type
  // Output stream
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [15:0]                      m_tdata,  // data_byte[7:0], message_ready[8],
                                                     // queue_empty[9], 0
  output logic                             m_tuser,  // from_copy
  output logic                             m_tlast,
  // Register port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sprq_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import sprq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  logic [BYTE_W-1:0] delimiter;
  req_t              req;
  res_t              res;
  logic              ram_we;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_waddr;
  logic [IDX_W-1:0]  ram_raddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [BYTE_W-1:0] ram_rdata;
  logic              addr_hit;

  // Register port: delimiter is the only register, word address 0.
  assign pready   = 1'b1;
  assign addr_hit = (paddr[ADDR_W-1:2] == ADDR_DELIM[ADDR_W-1:2]);
  assign prdata   = addr_hit ? {24'd0, delimiter} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter <= DELIM_RESET;
    end else if (psel && penable && pwrite && pready && addr_hit) begin
      delimiter <= pwdata[BYTE_W-1:0];
    end
  end

  // Beat unpacking and packing.
  assign req.req_type   = s_tuser;
  assign req.rx_byte    = s_tdata[7:0];
  assign req.copy_limit = s_tdata[14:8];

  assign m_tdata = {6'd0, res.queue_empty, res.message_ready, res.data_byte};
  assign m_tuser = res.from_copy;
  assign m_tlast = res.last;

  sprq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .delimiter (delimiter),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req       (req),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  sprq_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire

@@ rtl/core/sprq_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none
module sprq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port: data is registered on re and holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/sprq_ctrl.sv @@
// Queue sequencer: keeps head/tail/flags, drives the ring RAM and the result register.
// Depends on sprq_pkg; the ring store lives in an external sprq_ram instance.
`default_nettype none
module sprq_ctrl #(
  parameter int QUEUE_DEPTH = sprq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic [sprq_pkg::BYTE_W-1:0]         delimiter,
  // Request side
  input  wire logic                                req_valid,
  output logic                                     req_ready,
  input  wire sprq_pkg::req_t                      req,
  // Result side
  output logic                                     res_valid,
  input  wire logic                                res_ready,
  output sprq_pkg::res_t                           res,
  // Ring RAM
  output logic                                     ram_we,
  output logic [$clog2(QUEUE_DEPTH)-1:0]           ram_waddr,
  output logic [sprq_pkg::BYTE_W-1:0]              ram_wdata,
  output logic                                     ram_re,
  output logic [$clog2(QUEUE_DEPTH)-1:0]           ram_raddr,
  input  wire logic [sprq_pkg::BYTE_W-1:0]         ram_rdata
);
  import sprq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_RX_OUT    = 3'd1;
  localparam logic [2:0] ST_COPY_RD   = 3'd2;
  localparam logic [2:0] ST_COPY_WAIT = 3'd3;
  localparam logic [2:0] ST_COPY_END  = 3'd4;

  logic [2:0]         state, state_next;
  logic [IDX_W-1:0]   head, head_next;
  logic [IDX_W-1:0]   tail, tail_next;
  logic               empty_mark, empty_next;
  logic               ready_mark, ready_next;
  logic [LIMIT_W-1:0] copied, copied_next;
  logic [LIMIT_W-1:0] max_copy, max_copy_next;
  logic               out_valid, out_valid_next;
  res_t               out_res, out_res_next;

  logic               slot_free;
  logic [IDX_W-1:0]   head_inc;
  logic [IDX_W-1:0]   tail_inc;
  logic               pop_drains;

  // Ring index increments wrap at the configured depth.
  assign head_inc   = (head == IDX_LAST) ? '0 : head + 1'b1;
  assign tail_inc   = (tail == IDX_LAST) ? '0 : tail + 1'b1;
  assign pop_drains = (head_inc == tail);
  assign slot_free  = !out_valid || res_ready;

  assign req_ready = (state == ST_IDLE);
  assign res_valid = out_valid;
  assign res       = out_res;

  assign ram_waddr = tail;
  assign ram_wdata = req.rx_byte;
  assign ram_raddr = head;

  // Next-state and datapath logic.
  always_comb begin
    state_next     = state;
    head_next      = head;
    tail_next      = tail;
    empty_next     = empty_mark;
    ready_next     = ready_mark;
    copied_next    = copied;
    max_copy_next  = max_copy;
    out_valid_next = out_valid && !res_ready;
    out_res_next   = out_res;
    ram_we         = 1'b0;
    ram_re         = 1'b0;

    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (req.req_type == REQ_RX) begin
            if (req.rx_byte == delimiter) begin
              ready_next = 1'b1;
            end else begin
              // Push at the tail; a full ring drops its oldest byte.
              ram_we = 1'b1;
              if (head == tail && !empty_mark) begin
                head_next = head_inc;
              end
              tail_next  = tail_inc;
              empty_next = 1'b0;
            end
            state_next = ST_RX_OUT;
          end else begin
            copied_next   = '0;
            max_copy_next = (req.copy_limit == '0) ? '0 : req.copy_limit - 1'b1;
            state_next    = ST_COPY_RD;
          end
        end
      end

      ST_RX_OUT: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_res_next   = '{TERM_BYTE, 1'b0, 1'b1, ready_mark, empty_mark};
          state_next     = ST_IDLE;
        end
      end

      ST_COPY_RD: begin
        // Fetch the head byte while there is something left to copy.
        if (!empty_mark && copied < max_copy) begin
          ram_re     = 1'b1;
          state_next = ST_COPY_WAIT;
        end else begin
          state_next = ST_COPY_END;
        end
      end

      ST_COPY_WAIT: begin
        if (slot_free) begin
          head_next = head_inc;
          if (pop_drains) begin
            ready_next = 1'b0;
            head_next  = '0;
            tail_next  = '0;
            empty_next = 1'b1;
          end
          out_valid_next = 1'b1;
          out_res_next   = '{ram_rdata, 1'b1, 1'b0, ready_next, empty_next};
          copied_next    = copied + 1'b1;
          state_next     = ST_COPY_RD;
        end
      end

      ST_COPY_END: begin
        // Discard one more byte, if any, then emit the terminator.
        if (slot_free) begin
          if (!empty_mark) begin
            head_next = head_inc;
            if (pop_drains) begin
              ready_next = 1'b0;
              head_next  = '0;
              tail_next  = '0;
              empty_next = 1'b1;
            end
          end
          out_valid_next = 1'b1;
          out_res_next   = '{TERM_BYTE, 1'b1, 1'b1, ready_next, empty_next};
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= '0;
      tail       <= '0;
      empty_mark <= 1'b1;
      ready_mark <= 1'b0;
      copied     <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      tail       <= tail_next;
      empty_mark <= empty_next;
      ready_mark <= ready_next;
      copied     <= copied_next;
      out_valid  <= out_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    max_copy <= max_copy_next;
    out_res  <= out_res_next;
  end

endmodule
`default_nettype wire

@@ rtl/core/sprq_checker.sv @@
// Port-level checker for the serial receive ring queue, bound to the top level.
// Depends on sprq_pkg for field widths and the terminator byte.
`default_nettype none
module sprq_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic        m_tuser,
  input wire logic        m_tlast
);
  import sprq_pkg::*;

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result beat changed while stalled");

  // No result beat right after reset.
  a_reset: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result beat shown right after reset");

  // A receive status beat is a single, last beat with a zero byte.
  a_rx_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && m_tdata[BYTE_W-1:0] == TERM_BYTE)
    else $error("malformed receive status beat");

  // The copy terminator carries a zero byte.
  a_term: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser && m_tlast |-> m_tdata[BYTE_W-1:0] == TERM_BYTE)
    else $error("copy terminator byte not zero");

  // While a copied byte waits, the copy is still running and takes no new request.
  a_copy_ends: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser && !m_tlast |-> !s_tready)
    else $error("request accepted while a copy was still running");

endmodule

bind spi_rx_ring_queue_with_delimiter_top sprq_checker u_sprq_checker (.*);
`default_nettype wire

@@ test/tb_spi_rx_ring_queue_with_delimiter_top.sv @@
// Self-checking testbench for the serial receive ring queue with message delimiter.
// A directed table runs first, then random receive bursts and copy requests under
// several delimiter settings. Depends on sprq_pkg and spi_rx_ring_queue_with_delimiter_top.
module tb_spi_rx_ring_queue_with_delimiter_top;
  import sprq_pkg::*;

  localparam int RING_DEPTH = QUEUE_DEPTH_DEF;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [15:0] s_tdata;  // rx_byte[7:0], copy_limit[14:8], 0
  logic s_tuser;         // req_type
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;  // data_byte[7:0], message_ready[8], queue_empty[9], 0
  logic m_tuser;         // from_copy
  logic m_tlast;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // One row of the directed table; typed rows carry their own expected beat.
  typedef struct packed {
    req_t item;
    bit   typed;
    res_t want;
  } plan_row_t;

  // Shadow copy of the queue state.
  bit [7:0] ring_mem [RING_DEPTH];
  int       head_ptr = 0;
  int       tail_ptr = 0;
  bit       is_empty = 1'b1;
  bit       msg_ready = 1'b0;
  bit [7:0] delim_val = DELIM_RESET;

  res_t      due[$];
  plan_row_t plan[$];
  int        mismatch_count = 0;
  int        beat_count = 0;
  int        sent_count = 0;
  int        sink_wait = 0;
  bit        sink_quiet = 1'b0;
  bit        src_quiet = 1'b0;

  spi_rx_ring_queue_with_delimiter_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Hard stop in case the block hangs.
  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic log_mismatch(string msg);
    $display("MISMATCH %s", msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      log_mismatch($sformatf("beat %0d %s: got %0h, want %0h", beat_count, name, got, want));
  endtask

  function automatic res_t beat_of(bit [7:0] d, bit c, bit l, bit rdy, bit emp);
    res_t r;
    r.data_byte     = d;
    r.from_copy     = c;
    r.last          = l;
    r.message_ready = rdy;
    r.queue_empty   = emp;
    return r;
  endfunction

  function automatic req_t rx_item(bit [7:0] b);
    req_t r;
    r.req_type   = REQ_RX;
    r.rx_byte    = b;
    r.copy_limit = '0;
    return r;
  endfunction

  function automatic req_t copy_item(bit [6:0] lim);
    req_t r;
    r.req_type   = REQ_COPY;
    r.rx_byte    = '0;
    r.copy_limit = lim;
    return r;
  endfunction

  // Append at the tail; a full ring drops its oldest byte.
  function automatic void push_ring(bit [7:0] b);
    ring_mem[tail_ptr] = b;
    if (head_ptr == tail_ptr && !is_empty)
      head_ptr = (head_ptr + 1) % RING_DEPTH;
    tail_ptr = (tail_ptr + 1) % RING_DEPTH;
    is_empty = 1'b0;
  endfunction

  // Remove the oldest byte; emptying the ring clears the flag and both pointers.
  function automatic bit [7:0] pull_ring();
    bit [7:0] v;
    if (is_empty)
      return 8'h00;
    v = ring_mem[head_ptr];
    head_ptr = (head_ptr + 1) % RING_DEPTH;
    if (head_ptr == tail_ptr) begin
      msg_ready = 1'b0;
      head_ptr  = 0;
      tail_ptr  = 0;
      is_empty  = 1'b1;
    end
    return v;
  endfunction

  // Work out the result beats of one request and queue them.
  function automatic void queue_predict(req_t it);
    bit [7:0] v;
    int copied;
    int max_copy;
    if (it.req_type == REQ_RX) begin
      if (it.rx_byte == delim_val)
        msg_ready = 1'b1;
      else
        push_ring(it.rx_byte);
      due.push_back(beat_of(8'h00, 1'b0, 1'b1, msg_ready, is_empty));
    end else begin
      copied   = 0;
      max_copy = (it.copy_limit == 0) ? 0 : int'(it.copy_limit) - 1;
      while (!is_empty && copied < max_copy) begin
        v = pull_ring();
        due.push_back(beat_of(v, 1'b1, 1'b0, msg_ready, is_empty));
        copied++;
      end
      // One trailing byte is dropped before the terminator.
      void'(pull_ring());
      due.push_back(beat_of(TERM_BYTE, 1'b1, 1'b1, msg_ready, is_empty));
    end
  endfunction

  task automatic add_row(req_t it, bit typed, res_t want);
    plan_row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    plan.push_back(row);
  endtask

  // Drive one request beat after a random gap; entered and left at a falling edge.
  task automatic send_item(req_t it, bit typed, res_t want);
    int gap;
    int keep;
    if ($urandom_range(0, 14) == 0)
      src_quiet = !src_quiet;
    gap = src_quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      if (s_tvalid)
        s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    keep = due.size();
    queue_predict(it);
    if (typed) begin
      while (due.size() > keep)
        void'(due.pop_back());
      due.push_back(want);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.req_type;
    s_tdata  <= {1'b0, it.copy_limit, it.rx_byte};
    do @(posedge clk); while (!s_tready);
    sent_count++;
    @(negedge clk);
  endtask

  // Hold the input side until every expected beat has come out.
  task automatic drain_results();
    if (s_tvalid)
      s_tvalid <= 1'b0;
    do @(negedge clk); while (due.size() != 0);
  endtask

  // Write the delimiter register, then read it back.
  task automatic set_delimiter(bit [7:0] v);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= ADDR_DELIM;
    pwdata <= {24'h0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    delim_val = v;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'h0, v})
      log_mismatch($sformatf("delimiter readback: got %0h, want %0h", prdata, v));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Output side: random stall before each beat, with quiet stretches.
  always @(negedge clk) begin
    m_tready <= (sink_wait == 0);
  end

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      beat_count++;
      if (due.size() == 0) begin
        log_mismatch($sformatf("beat %0d arrived with nothing expected", beat_count));
      end else begin
        want = due.pop_front();
        check_field("data_byte", m_tdata[7:0], want.data_byte);
        check_field("from_copy", m_tuser, want.from_copy);
        check_field("last", m_tlast, want.last);
        check_field("message_ready", m_tdata[8], want.message_ready);
        check_field("queue_empty", m_tdata[9], want.queue_empty);
        check_field("tdata padding", m_tdata[15:10], 0);
      end
      if ($urandom_range(0, 24) == 0)
        sink_quiet = !sink_quiet;
      sink_wait = sink_quiet ? 0 : $urandom_range(0, 18);
    end else if (sink_wait > 0) begin
      sink_wait--;
    end
  end

  initial begin
    int phase;
    int phase_end;
    int pick;
    int n;
    int i;
    bit [7:0] b;
    bit [6:0] lim;

    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;

    // Directed table, delimiter at its reset value.
    // Copy on an empty queue gives only the terminator.
    add_row(copy_item(7'd0), 1'b1, beat_of(TERM_BYTE, 1'b1, 1'b1, 1'b0, 1'b1));
    // Delimiter while empty still raises the flag.
    add_row(rx_item(DELIM_RESET), 1'b1, beat_of(8'h00, 1'b0, 1'b1, 1'b1, 1'b1));
    // A discard on an empty queue leaves the flag set.
    add_row(copy_item(7'd1), 1'b1, beat_of(TERM_BYTE, 1'b1, 1'b1, 1'b1, 1'b1));
    add_row(rx_item(8'h00), 1'b1, beat_of(8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
    add_row(rx_item(8'hFF), 1'b1, beat_of(8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
    // Limit one copies nothing but drops the oldest byte.
    add_row(copy_item(7'd1), 1'b1, beat_of(TERM_BYTE, 1'b1, 1'b1, 1'b1, 1'b0));
    // Limit beyond contents stops when the queue empties.
    add_row(copy_item(7'd64), 1'b0, '0);
    add_row(rx_item(8'h01), 1'b0, '0);
    add_row(rx_item(8'h02), 1'b0, '0);
    add_row(rx_item(8'h03), 1'b0, '0);
    add_row(rx_item(8'h04), 1'b0, '0);
    add_row(copy_item(7'd2), 1'b0, '0);
    add_row(rx_item(DELIM_RESET), 1'b0, '0);
    add_row(copy_item(7'd3), 1'b0, '0);
    add_row(rx_item(8'h55), 1'b0, '0);
    add_row(rx_item(8'hAA), 1'b0, '0);
    add_row(copy_item(7'd64), 1'b0, '0);
    // Limit zero with a byte queued: the discard empties the queue.
    add_row(rx_item(8'h80), 1'b0, '0);
    add_row(copy_item(7'd0), 1'b0, '0);
    add_row(rx_item(8'h7F), 1'b0, '0);
    add_row(copy_item(7'd63), 1'b0, '0);
    add_row(copy_item(7'd2), 1'b0, '0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[k])
      send_item(plan[k].item, plan[k].typed, plan[k].want);

    // Random part: one delimiter setting per phase, the extremes first.
    for (phase = 0; phase < 4; phase++) begin
      drain_results();
      if (phase == 0)
        set_delimiter(8'h00);
      else if (phase == 1)
        set_delimiter(8'hFF);
      else
        set_delimiter(8'($urandom_range(0, 255)));
      phase_end = sent_count + 88;
      while (sent_count < phase_end) begin
        if ($urandom_range(0, 19) == 0)
          drain_results();
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          // A message: a burst of bytes, usually a delimiter, then a copy.
          n = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 45) : $urandom_range(0, 12);
          for (i = 0; i < n; i++) begin
            b = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 9) == 0)
              b = delim_val;
            send_item(rx_item(b), 1'b0, '0);
          end
          if ($urandom_range(0, 3) != 0)
            send_item(rx_item(delim_val), 1'b0, '0);
          if ($urandom_range(0, 3) == 0)
            lim = 7'(n + $urandom_range(0, 2));
          else
            lim = 7'($urandom_range(0, 64));
          send_item(copy_item(lim), 1'b0, '0);
        end else if (pick < 9) begin
          send_item(rx_item(8'($urandom_range(0, 255))), 1'b0, '0);
        end else begin
          send_item(copy_item(7'($urandom_range(0, 64))), 1'b0, '0);
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
